[hdl/hsnce_pkg.sv]
// ---------------------------------------------------------------------------
// hsnce_pkg - shared types, constants and microcode for the cell enumerator
// Widths of the cell grid fields, register indexes, the axis decode record
// and the control store of the step sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package hsnce_pkg;

  localparam int unsigned IDX_W   = 18;   // linear cell index
  localparam int unsigned CNT_W   = 7;    // cell count per axis
  localparam int unsigned CRD_W   = 6;    // cell coordinate per axis
  localparam int unsigned CNT_MAX = (2 ** CNT_W) - 1;
  localparam int unsigned MAX_CELLS_PER_AXIS = 64;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Z  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC = 2'd3;

  // signed unit steps, used for directions and box shifts
  localparam logic signed [1:0] DIR_NEG  = 2'sb11;
  localparam logic signed [1:0] DIR_ZERO = 2'sb00;
  localparam logic signed [1:0] DIR_POS  = 2'sb01;

  // candidate slot along one axis; open grid: below, same, above;
  // periodic grid: same, first list entry, second list entry
  localparam logic [1:0] SLOT_A = 2'd0;
  localparam logic [1:0] SLOT_B = 2'd1;
  localparam logic [1:0] SLOT_C = 2'd2;

  // step counter and fixed program addresses
  localparam int unsigned PC_W = 5;
  localparam logic [PC_W-1:0] PC_WAIT  = 5'd0;
  localparam logic [PC_W-1:0] PC_MUL1  = 5'd1;
  localparam logic [PC_W-1:0] PC_FLUSH = 5'd21;

  typedef enum logic [2:0] {
    OP_WAIT,    // take the next search cell
    OP_MUL1,    // z*ny + y, nx*ny
    OP_MUL2,    // search index, grid size; stage the search row
    OP_CAND,    // evaluate one neighbour candidate
    OP_FLUSH    // release the staged row as the final one
  } op_t;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_NO_ZROW   // taken when the upper z layer does not exist
  } jmp_t;

  typedef struct packed {
    op_t             op;
    logic            wait_in;
    logic            wait_out;
    jmp_t            jmp;
    logic [PC_W-1:0] target;
    logic            slot_z;
    logic [1:0]      slot_y;
    logic [1:0]      slot_x;
  } uword_t;

  typedef struct packed {
    logic              valid;
    logic signed [1:0] dir;
    logic signed [1:0] wrap;
    logic [IDX_W-1:0]  off;
  } axis_t;

  function automatic uword_t plain_word(input op_t op);
    uword_t w;
    w.op       = op;
    w.wait_in  = 1'b0;
    w.wait_out = 1'b0;
    w.jmp      = JMP_NONE;
    w.target   = PC_WAIT;
    w.slot_z   = 1'b0;
    w.slot_y   = SLOT_A;
    w.slot_x   = SLOT_A;
    return w;
  endfunction

  function automatic uword_t cand_word(input logic sz, input logic [1:0] sy,
                                       input logic [1:0] sx);
    uword_t w;
    w          = plain_word(OP_CAND);
    w.wait_out = 1'b1;
    w.slot_z   = sz;
    w.slot_y   = sy;
    w.slot_x   = sx;
    return w;
  endfunction

  // control store
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = plain_word(OP_WAIT);
    case (pc)
      5'd0: begin
        w         = plain_word(OP_WAIT);
        w.wait_in = 1'b1;
      end
      5'd1:  w = plain_word(OP_MUL1);
      5'd2:  w = plain_word(OP_MUL2);
      5'd3:  w = cand_word(1'b0, SLOT_A, SLOT_A);
      5'd4:  w = cand_word(1'b0, SLOT_A, SLOT_B);
      5'd5:  w = cand_word(1'b0, SLOT_A, SLOT_C);
      5'd6:  w = cand_word(1'b0, SLOT_B, SLOT_A);
      5'd7:  w = cand_word(1'b0, SLOT_B, SLOT_B);
      5'd8:  w = cand_word(1'b0, SLOT_B, SLOT_C);
      5'd9:  w = cand_word(1'b0, SLOT_C, SLOT_A);
      5'd10: w = cand_word(1'b0, SLOT_C, SLOT_B);
      5'd11: w = cand_word(1'b0, SLOT_C, SLOT_C);
      5'd12: begin
        w        = cand_word(1'b1, SLOT_A, SLOT_A);
        w.jmp    = JMP_NO_ZROW;
        w.target = PC_FLUSH;
      end
      5'd13: w = cand_word(1'b1, SLOT_A, SLOT_B);
      5'd14: w = cand_word(1'b1, SLOT_A, SLOT_C);
      5'd15: w = cand_word(1'b1, SLOT_B, SLOT_A);
      5'd16: w = cand_word(1'b1, SLOT_B, SLOT_B);
      5'd17: w = cand_word(1'b1, SLOT_B, SLOT_C);
      5'd18: w = cand_word(1'b1, SLOT_C, SLOT_A);
      5'd19: w = cand_word(1'b1, SLOT_C, SLOT_B);
      5'd20: w = cand_word(1'b1, SLOT_C, SLOT_C);
      5'd21: begin
        w          = plain_word(OP_FLUSH);
        w.wait_out = 1'b1;
        w.jmp      = JMP_ALWAYS;
        w.target   = PC_WAIT;
      end
      default: begin
        w        = plain_word(OP_FLUSH);
        w.jmp    = JMP_ALWAYS;
        w.target = PC_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[hdl/half_shell_neighbor_cell_enumerator.sv]
// ---------------------------------------------------------------------------
// half_shell_neighbor_cell_enumerator - half-shell neighbour cell search
// A step sequencer run from a control store walks the 18 candidate slots of
// a search cell and emits the search cell and every forward neighbour.
// ---------------------------------------------------------------------------
// The control program advances one step per cycle, except while the sequencer
//   waits for a search cell or for a stalled result channel; the upper z
//   layer steps are skipped when that layer is absent. A new search cell is
//   taken only at the wait step. The search row is offered when the first kept
//   candidate or the flush comes, later while the previous final row waits.
// Reset: grid 1 x 1 x 1, open boundaries, sequencer at its wait step, result
//   register empty; no clearing pass.
`default_nettype none

module half_shell_neighbor_cell_enumerator #(
  parameter int unsigned MAX_CELLS_PER_AXIS = hsnce_pkg::MAX_CELLS_PER_AXIS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [hsnce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hsnce_pkg::CNT_W-1:0]     cfg_wdata,
  // search cell in
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [hsnce_pkg::CRD_W-1:0]     in_cell_x,
  input  logic [hsnce_pkg::CRD_W-1:0]     in_cell_y,
  input  logic [hsnce_pkg::CRD_W-1:0]     in_cell_z,
  // result rows out
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [hsnce_pkg::IDX_W-1:0]     out_search_idx,
  output logic [hsnce_pkg::IDX_W-1:0]     out_pair_index,
  output logic                            out_is_search,
  output logic signed [1:0]               out_wrap_x,
  output logic signed [1:0]               out_wrap_y,
  output logic signed [0:0]               out_wrap_z,
  output logic                            out_last
);

  localparam int unsigned IDX_W = hsnce_pkg::IDX_W;
  localparam int unsigned CNT_W = hsnce_pkg::CNT_W;
  localparam int unsigned CRD_W = hsnce_pkg::CRD_W;
  localparam int unsigned PC_W  = hsnce_pkg::PC_W;
  localparam int unsigned T_W   = CRD_W + CNT_W;   // z*ny + y
  localparam int unsigned NXY_W = 2 * CNT_W;       // nx*ny
  localparam logic [CNT_W-1:0] CNT_SAT =
    CNT_W'((MAX_CELLS_PER_AXIS > hsnce_pkg::CNT_MAX) ? hsnce_pkg::CNT_MAX
                                                     : MAX_CELLS_PER_AXIS);

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > CNT_SAT) begin
      r = CNT_SAT;
    end
    return r;
  endfunction

  function automatic logic [CRD_W-1:0] clamp_coord(input logic [CRD_W-1:0] c,
                                                    input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] top;
    logic [CRD_W-1:0] r;
    top = n - CNT_W'(1);
    r   = c;
    if ({1'b0, c} >= n) begin
      r = top[CRD_W-1:0];
    end
    return r;
  endfunction

  // configuration
  logic [CNT_W-1:0] cnt_x_r, cnt_y_r, cnt_z_r;
  logic             periodic_r;

  // sequencer
  logic [PC_W-1:0]   pc_r, pc_nxt;
  hsnce_pkg::uword_t cw;

  // datapath
  logic [CRD_W-1:0] crd_x_r, crd_y_r, crd_z_r;
  logic [CRD_W-1:0] crd_x_nxt, crd_y_nxt, crd_z_nxt;
  logic [T_W-1:0]   t_r, t_nxt, zy_prod;
  logic [NXY_W-1:0] nxy_r, nxy_nxt;
  logic [IDX_W-1:0] ntot_r, ntot_nxt;
  logic [IDX_W-1:0] s_r, s_nxt;

  // staged row, released one kept candidate later so the final one is known
  logic [IDX_W-1:0]  pend_pair_r, pend_pair_nxt;
  logic              pend_is_search_r, pend_is_search_nxt;
  logic signed [1:0] pend_wx_r, pend_wx_nxt;
  logic signed [1:0] pend_wy_r, pend_wy_nxt;
  logic              pend_wz_r, pend_wz_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  out_search_r, out_search_nxt;
  logic [IDX_W-1:0]  out_pair_r, out_pair_nxt;
  logic              out_is_search_r, out_is_search_nxt;
  logic signed [1:0] out_wx_r, out_wx_nxt;
  logic signed [1:0] out_wy_r, out_wy_nxt;
  logic              out_wz_r, out_wz_nxt;
  logic              out_last_r, out_last_nxt;

  // candidate evaluation
  hsnce_pkg::axis_t ax, ay;
  logic             per;
  logic             z_last, zrow_ok, z_ok;
  logic [IDX_W-1:0] off_z, cand_pair;
  logic             cand_wz;
  logic             forward, kept, emit, out_free, hold;

  assign cw  = hsnce_pkg::ucode(pc_r);
  assign per = periodic_r && (cnt_x_r != CNT_W'(1)) && (cnt_y_r != CNT_W'(1))
               && (cnt_z_r != CNT_W'(1));

  hsnce_axis u_axis_x (
    .crd    (crd_x_r),
    .cnt    (cnt_x_r),
    .per    (per),
    .slot   (cw.slot_x),
    .stride (IDX_W'(1)),
    .span   (IDX_W'(cnt_x_r)),
    .dec    (ax)
  );

  hsnce_axis u_axis_y (
    .crd    (crd_y_r),
    .cnt    (cnt_y_r),
    .per    (per),
    .slot   (cw.slot_y),
    .stride (IDX_W'(cnt_x_r)),
    .span   (IDX_W'(nxy_r)),
    .dec    (ay)
  );

  // z only looks forward: same layer or the one above
  assign z_last  = ({1'b0, crd_z_r} == (cnt_z_r - CNT_W'(1)));
  assign zrow_ok = per || !z_last;
  assign z_ok    = !cw.slot_z || zrow_ok;
  assign cand_wz = cw.slot_z && per && z_last;
  assign off_z   = !cw.slot_z ? '0 :
                   cand_wz    ? (IDX_W'(nxy_r) - ntot_r) : IDX_W'(nxy_r);

  assign cand_pair = s_r + off_z + ay.off + ax.off;
  assign forward   = cw.slot_z || (ay.dir == hsnce_pkg::DIR_POS) ||
                     ((ay.dir == hsnce_pkg::DIR_ZERO) && (ax.dir == hsnce_pkg::DIR_POS));
  assign kept      = ax.valid && ay.valid && z_ok && forward;

  assign emit     = ((cw.op == hsnce_pkg::OP_CAND) && kept) ||
                    (cw.op == hsnce_pkg::OP_FLUSH);
  assign out_free = !out_valid_r || !out_stall;
  assign hold     = (cw.wait_in && !in_valid) || (cw.wait_out && emit && !out_free);

  assign in_stall = (cw.op != hsnce_pkg::OP_WAIT);

  // multipliers, each feeding a register
  assign zy_prod  = T_W'(crd_z_r) * T_W'(cnt_y_r);
  assign t_nxt    = zy_prod + T_W'(crd_y_r);
  assign nxy_nxt  = NXY_W'(cnt_x_r) * NXY_W'(cnt_y_r);
  assign s_nxt    = IDX_W'(t_r) * IDX_W'(cnt_x_r) + IDX_W'(crd_x_r);
  assign ntot_nxt = IDX_W'(nxy_r) * IDX_W'(cnt_z_r);

  always_comb begin
    pc_nxt = pc_r;
    if (!hold) begin
      case (cw.jmp)
        hsnce_pkg::JMP_ALWAYS:  pc_nxt = cw.target;
        hsnce_pkg::JMP_NO_ZROW: pc_nxt = zrow_ok ? (pc_r + PC_W'(1)) : cw.target;
        default:                pc_nxt = pc_r + PC_W'(1);
      endcase
    end
  end

  always_comb begin
    crd_x_nxt          = crd_x_r;
    crd_y_nxt          = crd_y_r;
    crd_z_nxt          = crd_z_r;
    pend_pair_nxt      = pend_pair_r;
    pend_is_search_nxt = pend_is_search_r;
    pend_wx_nxt        = pend_wx_r;
    pend_wy_nxt        = pend_wy_r;
    pend_wz_nxt        = pend_wz_r;
    out_search_nxt     = out_search_r;
    out_pair_nxt       = out_pair_r;
    out_is_search_nxt  = out_is_search_r;
    out_wx_nxt         = out_wx_r;
    out_wy_nxt         = out_wy_r;
    out_wz_nxt         = out_wz_r;
    out_last_nxt       = out_last_r;
    out_valid_nxt      = out_valid_r && out_stall;

    if ((cw.op == hsnce_pkg::OP_WAIT) && in_valid) begin
      crd_x_nxt = clamp_coord(in_cell_x, cnt_x_r);
      crd_y_nxt = clamp_coord(in_cell_y, cnt_y_r);
      crd_z_nxt = clamp_coord(in_cell_z, cnt_z_r);
    end

    if (cw.op == hsnce_pkg::OP_MUL2) begin
      pend_pair_nxt      = s_nxt;
      pend_is_search_nxt = 1'b1;
      pend_wx_nxt        = hsnce_pkg::DIR_ZERO;
      pend_wy_nxt        = hsnce_pkg::DIR_ZERO;
      pend_wz_nxt        = 1'b0;
    end

    // release the staged row; a kept candidate takes its place
    if (emit && out_free) begin
      out_valid_nxt     = 1'b1;
      out_search_nxt    = s_r;
      out_pair_nxt      = pend_pair_r;
      out_is_search_nxt = pend_is_search_r;
      out_wx_nxt        = pend_wx_r;
      out_wy_nxt        = pend_wy_r;
      out_wz_nxt        = pend_wz_r;
      out_last_nxt      = (cw.op == hsnce_pkg::OP_FLUSH);
      if (cw.op == hsnce_pkg::OP_CAND) begin
        pend_pair_nxt      = cand_pair;
        pend_is_search_nxt = 1'b0;
        pend_wx_nxt        = ax.wrap;
        pend_wy_nxt        = ay.wrap;
        pend_wz_nxt        = cand_wz;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_x_r     <= CNT_W'(1);
      cnt_y_r     <= CNT_W'(1);
      cnt_z_r     <= CNT_W'(1);
      periodic_r  <= 1'b0;
      pc_r        <= hsnce_pkg::PC_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          hsnce_pkg::CFG_CELLS_X:  cnt_x_r    <= clamp_count(cfg_wdata);
          hsnce_pkg::CFG_CELLS_Y:  cnt_y_r    <= clamp_count(cfg_wdata);
          hsnce_pkg::CFG_CELLS_Z:  cnt_z_r    <= clamp_count(cfg_wdata);
          hsnce_pkg::CFG_PERIODIC: periodic_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    crd_x_r <= crd_x_nxt;
    crd_y_r <= crd_y_nxt;
    crd_z_r <= crd_z_nxt;
    if (cw.op == hsnce_pkg::OP_MUL1) begin
      t_r   <= t_nxt;
      nxy_r <= nxy_nxt;
    end
    if (cw.op == hsnce_pkg::OP_MUL2) begin
      s_r    <= s_nxt;
      ntot_r <= ntot_nxt;
    end
    pend_pair_r      <= pend_pair_nxt;
    pend_is_search_r <= pend_is_search_nxt;
    pend_wx_r        <= pend_wx_nxt;
    pend_wy_r        <= pend_wy_nxt;
    pend_wz_r        <= pend_wz_nxt;
    out_search_r     <= out_search_nxt;
    out_pair_r       <= out_pair_nxt;
    out_is_search_r  <= out_is_search_nxt;
    out_wx_r         <= out_wx_nxt;
    out_wy_r         <= out_wy_nxt;
    out_wz_r         <= out_wz_nxt;
    out_last_r       <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_search_idx = out_search_r;
  assign out_pair_index = out_pair_r;
  assign out_is_search  = out_is_search_r;
  assign out_wrap_x     = out_wx_r;
  assign out_wrap_y     = out_wy_r;
  assign out_wrap_z     = out_wz_r;
  assign out_last       = out_last_r;

  // an accepted search cell starts the multiply steps
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> pc_r == hsnce_pkg::PC_MUL1)
    else $error("sequencer did not start after a search cell transfer");

  // the final release returns to the wait step with a last row on offer
  a_flush_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (cw.op == hsnce_pkg::OP_FLUSH) && out_free |=>
      (pc_r == hsnce_pkg::PC_WAIT) && out_valid_r && out_last_r)
    else $error("final row not released correctly");

  // the search row names the search cell alone, unshifted
  a_search_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_is_search_r |->
      (out_pair_r == out_search_r) && (out_wx_r == hsnce_pkg::DIR_ZERO) &&
      (out_wy_r == hsnce_pkg::DIR_ZERO) && !out_wz_r)
    else $error("search row carries a neighbour or a shift");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= hsnce_pkg::PC_FLUSH)
    else $error("step counter beyond the program");

endmodule

`default_nettype wire

[hdl/hsnce_axis.sv]
// ---------------------------------------------------------------------------
// hsnce_axis - neighbour slot decode for one axis
// Gives existence, direction, box shift and index offset of one candidate
// slot along an axis, for open and periodic grids.
// ---------------------------------------------------------------------------
`default_nettype none

module hsnce_axis (
  input  logic [hsnce_pkg::CRD_W-1:0] crd,
  input  logic [hsnce_pkg::CNT_W-1:0] cnt,
  input  logic                        per,
  input  logic [1:0]                  slot,
  input  logic [hsnce_pkg::IDX_W-1:0] stride,   // index step of one cell
  input  logic [hsnce_pkg::IDX_W-1:0] span,     // index step of one box
  output hsnce_pkg::axis_t            dec
);

  logic at_first;
  logic at_last;

  assign at_first = (crd == '0);
  assign at_last  = ({1'b0, crd} == (cnt - hsnce_pkg::CNT_W'(1)));

  always_comb begin
    dec.valid = 1'b0;
    dec.dir   = hsnce_pkg::DIR_ZERO;
    dec.wrap  = hsnce_pkg::DIR_ZERO;
    dec.off   = '0;
    case (slot)
      hsnce_pkg::SLOT_A: begin
        if (per) begin
          dec.valid = 1'b1;
        end else begin
          dec.valid = !at_first;
          dec.dir   = hsnce_pkg::DIR_NEG;
          dec.off   = '0 - stride;
        end
      end
      hsnce_pkg::SLOT_B: begin
        dec.valid = 1'b1;
        if (per) begin
          if (at_first) begin
            dec.dir = hsnce_pkg::DIR_POS;
            dec.off = stride;
          end else begin
            dec.dir = hsnce_pkg::DIR_NEG;
            dec.off = '0 - stride;
          end
        end
      end
      hsnce_pkg::SLOT_C: begin
        if (per) begin
          dec.valid = 1'b1;
          if (at_first) begin
            // lower wrap: far cell, search shifted up one box
            dec.dir  = hsnce_pkg::DIR_NEG;
            dec.wrap = hsnce_pkg::DIR_POS;
            dec.off  = span - stride;
          end else if (at_last) begin
            dec.dir  = hsnce_pkg::DIR_POS;
            dec.wrap = hsnce_pkg::DIR_NEG;
            dec.off  = stride - span;
          end else begin
            dec.dir = hsnce_pkg::DIR_POS;
            dec.off = stride;
          end
        end else begin
          dec.valid = !at_last;
          dec.dir   = hsnce_pkg::DIR_POS;
          dec.off   = stride;
        end
      end
      default: begin
        dec.valid = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire
